[design/mwsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwsm_pkg
// types and constants shared by the mecanum wheel speed mixer
// ----------------------------------------------------------------------------
package mwsm_pkg;

    localparam int SPD_W      = 16;
    localparam int REG_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_WHEELS = 4;
    localparam int SUM_W      = 18;
    localparam int MAG_W      = 17;
    localparam int PROD_W     = MAG_W + REG_W;
    localparam int QUO_W      = REG_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_X   = 2'd0,
        CFG_LIMIT_Y   = 2'd1,
        CFG_LIMIT_ROT = 2'd2,
        CFG_WHEEL_MAX = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SPD_W-1:0] speed_x;
        logic signed [SPD_W-1:0] speed_y;
        logic signed [SPD_W-1:0] speed_rot;
    } cmd_t;

    typedef struct packed {
        logic signed [SPD_W-1:0] wheel_0;
        logic signed [SPD_W-1:0] wheel_1;
        logic signed [SPD_W-1:0] wheel_2;
        logic signed [SPD_W-1:0] wheel_3;
    } wheel_t;

    typedef struct packed {
        logic [PROD_W-1:0]       rem;
        logic [QUO_W-1:0]        quo;
        logic                    neg;
        logic signed [SPD_W-1:0] sat;
    } div_lane_t;

endpackage

[design/mecanum_wheel_speed_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mix
// four-wheel mecanum inverse kinematics with clamping and proportional scaling
// ----------------------------------------------------------------------------
// A chassis command (x, y, rotation) is taken on the cmd channel when
// cmd_valid and cmd_ready are both high; the four wheel speeds leave on the
// wheels channel when wheel_valid and wheel_ready are both high. One result
// per command, in order.
// Throughput is one command per cycle while wheel_ready holds: the scaling
// divide is a 15-stage restoring divider per wheel, one quotient bit a stage,
// behind clamp, sum, max and multiply stages and ahead of the output register.
// Each stage holds its own valid bit and advances when the next stage is
// empty or moving, so a stall on the wheels channel fills bubbles first and
// then holds cmd_ready low; nothing is lost or repeated.
// User must write limits via cfg_write_en/cfg_index/cfg_data only while the
// block is idle; unenforced. Reset empties the pipeline, sets limits to 32767.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mix (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  mwsm_pkg::cmd_t                  cmd,
    output logic                            wheel_valid,
    input  logic                            wheel_ready,
    output mwsm_pkg::wheel_t                wheels,
    input  logic                            cfg_write_en,
    input  logic [mwsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwsm_pkg::REG_W-1:0]      cfg_data
);
    import mwsm_pkg::*;

    localparam int DIV_N  = QUO_W;
    localparam int V_CLMP = 0;
    localparam int V_SUM  = 1;
    localparam int V_PAIR = 2;
    localparam int V_MAG  = 3;
    localparam int V_DIV  = 4;
    localparam int V_OUT  = V_DIV + DIV_N + 1;
    localparam int NST    = V_OUT + 1;

    logic [REG_W-1:0] limit_x_reg;
    logic [REG_W-1:0] limit_y_reg;
    logic [REG_W-1:0] limit_rot_reg;
    logic [REG_W-1:0] wheel_max_reg;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    logic signed [SPD_W-1:0] x_reg, y_reg, w_reg;
    logic signed [SUM_W-1:0] sum_reg  [NUM_WHEELS];
    logic [MAG_W-1:0]        abs_reg  [NUM_WHEELS];
    logic signed [SUM_W-1:0] sum3_reg [NUM_WHEELS];
    logic [MAG_W-1:0]        abs3_reg [NUM_WHEELS];
    logic [MAG_W-1:0]        max01_reg, max23_reg;
    logic signed [SUM_W-1:0] sum4_reg [NUM_WHEELS];
    logic [MAG_W-1:0]        abs4_reg [NUM_WHEELS];
    logic [MAG_W-1:0]        mag_reg;

    div_lane_t        lane_reg  [DIV_N+1][NUM_WHEELS];
    div_lane_t        lane_next [DIV_N][NUM_WHEELS];
    logic [MAG_W-1:0] dsor_reg  [DIV_N+1];
    logic             scale_reg [DIV_N+1];

    wheel_t wheels_reg;

    logic signed [SPD_W-1:0] x_next, y_next, w_next;
    logic signed [SUM_W-1:0] sum_next [NUM_WHEELS];
    logic [MAG_W-1:0]        abs_next [NUM_WHEELS];
    div_lane_t               lane0_next [NUM_WHEELS];
    logic signed [SPD_W-1:0] res_next [NUM_WHEELS];
    logic [PROD_W-1:0]       trial;

    function automatic logic signed [SPD_W-1:0] clamp_sym(
        input logic signed [SPD_W-1:0] v,
        input logic [REG_W-1:0]        lim
    );
        logic signed [SPD_W:0] l;
        logic signed [SPD_W:0] ve;
        logic signed [SPD_W:0] r;
        l  = $signed({2'b00, lim});
        ve = {v[SPD_W-1], v};
        if (ve > l) begin
            r = l;
        end else if (ve < -l) begin
            r = -l;
        end else begin
            r = ve;
        end
        return r[SPD_W-1:0];
    endfunction

    function automatic logic signed [SPD_W-1:0] sat16(input logic signed [SUM_W-1:0] t);
        logic signed [SPD_W-1:0] r;
        if (t > $signed(SUM_W'(32767))) begin
            r = 16'sh7fff;
        end else if (t < -$signed(SUM_W'(32768))) begin
            r = 16'sh8000;
        end else begin
            r = t[SPD_W-1:0];
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg   <= '1;
            limit_y_reg   <= '1;
            limit_rot_reg <= '1;
            wheel_max_reg <= '1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LIMIT_X:   limit_x_reg   <= cfg_data;
                CFG_LIMIT_Y:   limit_y_reg   <= cfg_data;
                CFG_LIMIT_ROT: limit_rot_reg <= cfg_data;
                CFG_WHEEL_MAX: wheel_max_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // per-stage ready: a stage moves when empty or when the next one moves
    always_comb
    begin
        rdy[NST] = wheel_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign cmd_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= cmd_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // datapath logic
    always_comb
    begin
        x_next = clamp_sym(cmd.speed_x, limit_x_reg);
        y_next = clamp_sym(cmd.speed_y, limit_y_reg);
        w_next = clamp_sym(cmd.speed_rot, limit_rot_reg);

        sum_next[0] = SUM_W'(x_reg) - SUM_W'(y_reg) + SUM_W'(w_reg);
        sum_next[1] = SUM_W'(x_reg) + SUM_W'(y_reg) + SUM_W'(w_reg);
        sum_next[2] = -SUM_W'(x_reg) + SUM_W'(y_reg) + SUM_W'(w_reg);
        sum_next[3] = -SUM_W'(x_reg) - SUM_W'(y_reg) + SUM_W'(w_reg);
        for (int l = 0; l < NUM_WHEELS; l++)
        begin
            abs_next[l] = sum_next[l][SUM_W-1] ? MAG_W'(-sum_next[l])
                                               : MAG_W'(sum_next[l]);
        end

        for (int l = 0; l < NUM_WHEELS; l++)
        begin
            lane0_next[l].rem = PROD_W'(abs4_reg[l]) * PROD_W'(wheel_max_reg);
            lane0_next[l].quo = '0;
            lane0_next[l].neg = sum4_reg[l][SUM_W-1];
            lane0_next[l].sat = sat16(sum4_reg[l]);
        end

        // restoring divide, one quotient bit a stage, msb first
        trial = '0;
        for (int j = 0; j < DIV_N; j++)
        begin
            trial = PROD_W'(dsor_reg[j]) << (DIV_N - 1 - j);
            for (int l = 0; l < NUM_WHEELS; l++)
            begin
                lane_next[j][l] = lane_reg[j][l];
                if (lane_reg[j][l].rem >= trial)
                begin
                    lane_next[j][l].rem = lane_reg[j][l].rem - trial;
                    lane_next[j][l].quo[DIV_N-1-j] = 1'b1;
                end
            end
        end

        for (int l = 0; l < NUM_WHEELS; l++)
        begin
            if (scale_reg[DIV_N])
            begin
                res_next[l] = lane_reg[DIV_N][l].neg
                            ? -$signed({1'b0, lane_reg[DIV_N][l].quo})
                            :  $signed({1'b0, lane_reg[DIV_N][l].quo});
            end
            else
            begin
                res_next[l] = lane_reg[DIV_N][l].sat;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (rdy[V_CLMP])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            w_reg <= w_next;
        end
        if (rdy[V_SUM])
        begin
            sum_reg <= sum_next;
            abs_reg <= abs_next;
        end
        if (rdy[V_PAIR])
        begin
            sum3_reg  <= sum_reg;
            abs3_reg  <= abs_reg;
            max01_reg <= (abs_reg[1] > abs_reg[0]) ? abs_reg[1] : abs_reg[0];
            max23_reg <= (abs_reg[3] > abs_reg[2]) ? abs_reg[3] : abs_reg[2];
        end
        if (rdy[V_MAG])
        begin
            sum4_reg <= sum3_reg;
            abs4_reg <= abs3_reg;
            mag_reg  <= (max23_reg > max01_reg) ? max23_reg : max01_reg;
        end
        if (rdy[V_DIV])
        begin
            lane_reg[0]  <= lane0_next;
            dsor_reg[0]  <= mag_reg;
            scale_reg[0] <= mag_reg > MAG_W'(wheel_max_reg);
        end
        for (int j = 0; j < DIV_N; j++)
        begin
            if (rdy[V_DIV+j+1])
            begin
                lane_reg[j+1]  <= lane_next[j];
                dsor_reg[j+1]  <= dsor_reg[j];
                scale_reg[j+1] <= scale_reg[j];
            end
        end
        if (rdy[V_OUT])
        begin
            wheels_reg.wheel_0 <= res_next[0];
            wheels_reg.wheel_1 <= res_next[1];
            wheels_reg.wheel_2 <= res_next[2];
            wheels_reg.wheel_3 <= res_next[3];
        end
    end

    assign wheel_valid = vld_reg[V_OUT];
    assign wheels      = wheels_reg;

endmodule
